// ----- hdl/wtls_pkg.sv -----
// Package for the weighted two-term least-squares core.
// Holds beat types, controller/datapath command and status structs, and sizes.
// No dependencies.
package wtls_pkg;

    localparam int SUM_W     = 64;   // accumulator width, scale 2^-32
    localparam int PROD_W    = 129;  // signed width of products and differences
    localparam int MAG_W     = 128;  // unsigned magnitude of a wide product
    localparam int NUM_W     = 145;  // dividend: magnitude shifted by 16 plus half divisor
    localparam int COEF_W    = 32;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = 8;
    localparam int PROD_LAST = 5;    // six wide products per solve
    localparam int STEP_STORE = 6;   // product step that writes the result

    typedef struct packed {
        logic signed [15:0] data_value;
        logic signed [15:0] model_one;
        logic signed [15:0] model_two;
        logic        [15:0] weight;
        logic               valid_req;
        logic               last_item;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] coef_one;
        logic signed [31:0] coef_two;
        logic               solved;
    } result_t;

    typedef struct packed {
        logic load;
        logic mul_terms;
        logic mul_weight;
        logic accum;
        logic prod_init;
        logic prod_run;
        logic check;
        logic div_init;
        logic div_run;
        logic div_store;
        logic div_sel;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic prod_done;
        logic div_done;
        logic ok;
    } stat_t;

endpackage

// ----- hdl/wtls_ctrl.sv -----
// Controller state machine for the weighted two-term least-squares core.
// Depends on wtls_pkg (cmd_t, stat_t).
module wtls_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           sample_valid,
    output logic           sample_ready,
    output logic           result_valid,
    input  logic           result_ready,
    input  wtls_pkg::stat_t stat,
    output wtls_pkg::cmd_t  cmd
);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b000000000001,
        ST_TERMS     = 12'b000000000010,
        ST_WEIGHT    = 12'b000000000100,
        ST_ACCUM     = 12'b000000001000,
        ST_PROD      = 12'b000000010000,
        ST_CHECK     = 12'b000000100000,
        ST_DIV_ONE   = 12'b000001000000,
        ST_STORE_ONE = 12'b000010000000,
        ST_INIT_TWO  = 12'b000100000000,
        ST_DIV_TWO   = 12'b001000000000,
        ST_STORE_TWO = 12'b010000000000,
        ST_FINISH    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !result_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TERMS;
                end
            end
            ST_TERMS:
            begin
                cmd.mul_terms = 1'b1;
                state_next    = ST_WEIGHT;
            end
            ST_WEIGHT:
            begin
                cmd.mul_weight = 1'b1;
                state_next     = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (stat.last)
                begin
                    cmd.prod_init = 1'b1;
                    state_next    = ST_PROD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PROD:
            begin
                cmd.prod_run = 1'b1;
                if (stat.prod_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.ok)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV_ONE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV_ONE:
            begin
                cmd.div_run = 1'b1;
                if (stat.div_done)
                    state_next = ST_STORE_ONE;
            end
            ST_STORE_ONE:
            begin
                cmd.div_store = 1'b1;
                state_next    = ST_INIT_TWO;
            end
            ST_INIT_TWO:
            begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = 1'b1;
                state_next   = ST_DIV_TWO;
            end
            ST_DIV_TWO:
            begin
                cmd.div_run = 1'b1;
                cmd.div_sel = 1'b1;
                if (stat.div_done)
                    state_next = ST_STORE_TWO;
            end
            ST_STORE_TWO:
            begin
                cmd.div_store = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

// ----- hdl/wtls_dp.sv -----
// Datapath: weighted accumulators, shared 32x32 partial-product multiplier,
// bit-serial restoring divider and result register. Depends on wtls_pkg.
module wtls_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  wtls_pkg::sample_t sample,
    input  wtls_pkg::cmd_t    cmd,
    output wtls_pkg::stat_t   stat,
    output wtls_pkg::result_t result
);

    localparam int SW = wtls_pkg::SUM_W;
    localparam int PW = wtls_pkg::PROD_W;
    localparam int MW = wtls_pkg::MAG_W;
    localparam int NW = wtls_pkg::NUM_W;
    localparam int CW = wtls_pkg::COEF_W;

    // ---------------- accumulation ----------------
    wtls_pkg::sample_t item_reg;
    logic signed [31:0] p11_reg, p12_reg, p22_reg, pd1_reg, pd2_reg;
    logic signed [48:0] w11_reg, w12_reg, w22_reg, wd1_reg, wd2_reg;
    logic signed [16:0] wt;
    logic [SW-1:0] a11_reg, a12_reg, a22_reg, b1_reg, b2_reg;

    assign wt = $signed({1'b0, item_reg.weight});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= sample;
        if (cmd.mul_terms)
        begin
            p11_reg <= item_reg.model_one * item_reg.model_one;
            p12_reg <= item_reg.model_one * item_reg.model_two;
            p22_reg <= item_reg.model_two * item_reg.model_two;
            pd1_reg <= item_reg.data_value * item_reg.model_one;
            pd2_reg <= item_reg.data_value * item_reg.model_two;
        end
        if (cmd.mul_weight)
        begin
            w11_reg <= p11_reg * wt;
            w12_reg <= p12_reg * wt;
            w22_reg <= p22_reg * wt;
            wd1_reg <= pd1_reg * wt;
            wd2_reg <= pd2_reg * wt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a11_reg <= '0;
            a12_reg <= '0;
            a22_reg <= '0;
            b1_reg  <= '0;
            b2_reg  <= '0;
        end
        else if (cmd.finish)
        begin
            a11_reg <= '0;
            a12_reg <= '0;
            a22_reg <= '0;
            b1_reg  <= '0;
            b2_reg  <= '0;
        end
        else if (cmd.accum && item_reg.valid_req)
        begin
            a11_reg <= a11_reg + SW'(w11_reg);
            a12_reg <= a12_reg + SW'(w12_reg);
            a22_reg <= a22_reg + SW'(w22_reg);
            b1_reg  <= b1_reg  + SW'(wd1_reg);
            b2_reg  <= b2_reg  + SW'(wd2_reg);
        end
    end

    // ---------------- wide products ----------------
    // step 0 latch magnitudes, steps 1-4 partial products, steps 2-5 add, step 6 store
    logic [2:0]    step_reg;
    logic [2:0]    idx_reg;
    logic [SW-1:0] opa, opb;
    logic [SW-1:0] ma_reg, mb_reg;
    logic          neg_reg;
    logic [63:0]   pp_reg;
    logic [MW-1:0] acc_reg;
    logic [1:0]    mk, ak;
    logic [MW-1:0] pp_shift;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] t1_reg, det_reg, n1_reg, n2_reg;
    logic signed [PW-1:0] diff;

    always_comb
    begin
        case (idx_reg)
            3'd0:    begin opa = a11_reg; opb = a22_reg; end
            3'd1:    begin opa = a12_reg; opb = a12_reg; end
            3'd2:    begin opa = a22_reg; opb = b1_reg;  end
            3'd3:    begin opa = a12_reg; opb = b2_reg;  end
            3'd4:    begin opa = a11_reg; opb = b2_reg;  end
            default: begin opa = a12_reg; opb = b1_reg;  end
        endcase
    end

    assign mk = 2'(step_reg - 3'd1);
    assign ak = 2'(step_reg - 3'd2);

    always_comb
    begin
        case (ak)
            2'd0:    pp_shift = MW'(pp_reg);
            2'd3:    pp_shift = MW'(pp_reg) << 64;
            default: pp_shift = MW'(pp_reg) << 32;
        endcase
    end

    assign prod = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign diff = t1_reg - prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.prod_init)
        begin
            step_reg <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.prod_run)
        begin
            if (step_reg == 3'(wtls_pkg::STEP_STORE))
            begin
                step_reg <= '0;
                idx_reg  <= idx_reg + 3'd1;
            end
            else
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prod_run)
        begin
            if (step_reg == 3'd0)
            begin
                ma_reg  <= opa[SW-1] ? -opa : opa;
                mb_reg  <= opb[SW-1] ? -opb : opb;
                neg_reg <= opa[SW-1] ^ opb[SW-1];
                acc_reg <= '0;
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4)
                pp_reg <= (mk[0] ? ma_reg[63:32] : ma_reg[31:0])
                        * (mk[1] ? mb_reg[63:32] : mb_reg[31:0]);
            if (step_reg >= 3'd2 && step_reg <= 3'd5)
                acc_reg <= acc_reg + pp_shift;
            if (step_reg == 3'(wtls_pkg::STEP_STORE))
            begin
                case (idx_reg)
                    3'd1:    det_reg <= diff;
                    3'd3:    n1_reg  <= diff;
                    3'd5:    n2_reg  <= diff;
                    default: t1_reg  <= prod;
                endcase
            end
        end
    end

    assign stat.prod_done = cmd.prod_run && step_reg == 3'(wtls_pkg::STEP_STORE)
                            && idx_reg == 3'(wtls_pkg::PROD_LAST);
    assign stat.ok   = !a11_reg[SW-1] && (a11_reg != '0)
                       && !det_reg[PW-1] && (det_reg != '0);
    assign stat.last = item_reg.last_item;

    // ---------------- division ----------------
    logic [NW-1:0]  num_reg;
    logic [MW-1:0]  rem_reg;
    logic [CW-1:0]  q_reg;
    logic           ovf_reg, dneg_reg, ok_reg;
    logic [wtls_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic signed [PW-1:0] nsel;
    logic [PW-1:0]  nmag;
    logic [MW-1:0]  trial;
    logic           fits;
    logic [CW-1:0]  lim, mag32, coef;
    logic signed [CW-1:0] coef1_reg, coef2_reg;

    assign nsel  = cmd.div_sel ? n2_reg : n1_reg;
    assign nmag  = nsel[PW-1] ? PW'(-nsel) : PW'(nsel);
    assign trial = {rem_reg[MW-2:0], num_reg[NW-1]};
    assign fits  = trial >= det_reg[MW-1:0];

    assign lim   = dneg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign mag32 = (ovf_reg || q_reg > lim) ? lim : q_reg;
    assign coef  = dneg_reg ? -mag32 : mag32;

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            num_reg  <= {1'b0, nmag[MW-1:0], 16'd0} + NW'(det_reg[MW-1:1]);
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            dneg_reg <= nsel[PW-1];
            cnt_reg  <= '0;
        end
        else if (cmd.div_run)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? trial - det_reg[MW-1:0] : trial;
            q_reg   <= {q_reg[CW-2:0], fits};
            ovf_reg <= ovf_reg | q_reg[CW-1];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.check)
        begin
            ok_reg    <= stat.ok;
            coef1_reg <= '0;
            coef2_reg <= '0;
        end
        else if (cmd.div_store)
        begin
            if (cmd.div_sel)
                coef2_reg <= coef;
            else
                coef1_reg <= coef;
        end
        if (cmd.finish)
        begin
            result.coef_one <= coef1_reg;
            result.coef_two <= coef2_reg;
            result.solved   <= ok_reg;
        end
    end

    assign stat.div_done = cmd.div_run
                           && cnt_reg == wtls_pkg::DIV_CNT_W'(wtls_pkg::DIV_STEPS - 1);

endmodule

// ----- hdl/weighted_two_term_least_squares_core.sv -----
// Top level of the weighted two-term least-squares core.
// Depends on wtls_pkg, wtls_ctrl and wtls_dp.
//
//   channel  | signals                              | beat
//   ---------+--------------------------------------+-----------------------------
//   sample   | sample_valid, sample_ready, sample   | one weighted sample
//   result   | result_valid, result_ready, result   | coefficients, after last_item
//
// An ordinary sample passes through accept, term multiply, weight multiply and accumulate.
// A last sample adds the solve: six wide products on one shared 32x32 multiplier,
// a check and, when solvable, two 145-step restoring divisions (the first initialised
// in the check state), then a load of the result register.
// The result register frees the sample side; a stalled result only holds the next solve.
// Reset clears the sums and the controller.
module weighted_two_term_least_squares_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  wtls_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output wtls_pkg::result_t result
);

    wtls_pkg::cmd_t  cmd;
    wtls_pkg::stat_t stat;

    wtls_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    wtls_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

`ifndef ASSERT_OFF
    a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.solved |-> result.coef_one == 0 && result.coef_two == 0)
        else $error("unsolved result carries nonzero coefficients");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample accepted while previous one still in work");

    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.accum, cmd.prod_run, cmd.div_run, cmd.finish}) <= 1)
        else $error("datapath phases overlap");
`endif

endmodule

// ----- sim/tb_weighted_two_term_least_squares_core.sv -----
// Testbench for the weighted two-term least-squares core: a directed table and
// random fit ranges, each result checked against a fixed-point solve computed here.
// Depends on wtls_pkg and weighted_two_term_least_squares_core.
module tb_weighted_two_term_least_squares_core;

    localparam int DRAIN_CYCLES  = 400;
    localparam int IDLE_LIMIT    = 20000;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int LONG_HOLD     = 1500;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_ready;
    wtls_pkg::sample_t sample;
    logic              result_valid;
    logic              result_ready;
    wtls_pkg::result_t result;

    weighted_two_term_least_squares_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // running sums of the fit, scale 2^-32
    logic [63:0]       acc_11, acc_12, acc_22, acc_d1, acc_d2;
    wtls_pkg::result_t coef_queue[$];
    int                error_count = 0;
    int                idle_cycles = 0;
    idle_mode_t        idle_mode;
    bit                hold_off;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("mismatch %s: got %h want %h", what, got, want);
            error_count++;
        end
    endtask

    // round(n * 2^16 / d), ties away from zero, saturated to Q16.16
    function automatic logic [31:0] coef_of(input logic signed [159:0] n,
                                            input logic signed [159:0] d);
        logic [159:0] mag;
        logic [159:0] q;
        logic [159:0] lim;
        begin
            mag = (n < 0) ? -n : n;
            q = ((mag << 16) + (d >>> 1)) / d;
            lim = (n < 0) ? 160'h8000_0000 : 160'h7FFF_FFFF;
            if (q > lim)
                q = lim;
            coef_of = (n < 0) ? -q[31:0] : q[31:0];
        end
    endfunction

    task automatic fit_sample(input wtls_pkg::sample_t s);
        logic signed [63:0] d, m1, m2, w;
        logic signed [159:0] a11, a12, a22, b1, b2, det;
        wtls_pkg::result_t r;
        begin
            if (s.valid_req)
            begin
                d  = s.data_value;
                m1 = s.model_one;
                m2 = s.model_two;
                w  = {48'd0, s.weight};
                acc_11 += m1 * m1 * w;
                acc_12 += m1 * m2 * w;
                acc_22 += m2 * m2 * w;
                acc_d1 += d * m1 * w;
                acc_d2 += d * m2 * w;
            end
            if (s.last_item)
            begin
                a11 = $signed(acc_11);
                a12 = $signed(acc_12);
                a22 = $signed(acc_22);
                b1  = $signed(acc_d1);
                b2  = $signed(acc_d2);
                det = a11 * a22 - a12 * a12;
                r = '0;
                if (a11 > 0 && det > 0)
                begin
                    r.solved   = 1'b1;
                    r.coef_one = coef_of(a22 * b1 - a12 * b2, det);
                    r.coef_two = coef_of(a11 * b2 - a12 * b1, det);
                end
                coef_queue.push_back(r);
                acc_11 = '0; acc_12 = '0; acc_22 = '0; acc_d1 = '0; acc_d2 = '0;
            end
        end
    endtask

    function automatic bit idle_now(input bit send_side);
        begin
            case (idle_mode)
                IDLE_SEND: idle_now = send_side && ($urandom_range(99) < 49);
                IDLE_RECV: idle_now = !send_side && ($urandom_range(99) < 49);
                IDLE_BOTH: idle_now = $urandom_range(99) < 36;
                default:   idle_now = 1'b0;
            endcase
        end
    endfunction

    // drop valid only while idling, so back-to-back beats keep it high
    task automatic send_beat(input wtls_pkg::sample_t s);
        begin
            while (idle_now(1'b1))
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
            end
            sample_valid <= 1'b1;
            sample       <= s;
            @(posedge clk);
            while (!sample_ready)
                @(posedge clk);
            fit_sample(s);
        end
    endtask

    function automatic logic [15:0] rand_field();
        begin
            case ($urandom_range(5))
                0:       rand_field = 16'h7FFF;
                1:       rand_field = 16'h8000;
                2:       rand_field = 16'h0000;
                default: rand_field = 16'($urandom);
            endcase
        end
    endfunction

    function automatic wtls_pkg::sample_t rand_sample(input bit last, input bit mostly_valid);
        wtls_pkg::sample_t s;
        begin
            s.data_value = rand_field();
            s.model_one  = rand_field();
            s.model_two  = rand_field();
            s.weight     = rand_field();
            s.valid_req  = mostly_valid ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
            s.last_item  = last;
            rand_sample  = s;
        end
    endfunction

    task automatic wait_drained();
        begin
            sample_valid <= 1'b0;
            while (coef_queue.size() != 0)
                @(posedge clk);
        end
    endtask

    // receiver: stall by mode, or hold off entirely while asked
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= !hold_off && !idle_now(1'b0);
    end

    always @(posedge clk)
    begin
        wtls_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (coef_queue.size() == 0)
            begin
                $display("mismatch: unexpected result beat");
                error_count++;
            end
            else
            begin
                want = coef_queue.pop_front();
                if (result.coef_one !== want.coef_one)
                    report_mismatch("coef_one", result.coef_one, want.coef_one);
                if (result.coef_two !== want.coef_two)
                    report_mismatch("coef_two", result.coef_two, want.coef_two);
                if (result.solved !== want.solved)
                    report_mismatch("solved", {31'd0, result.solved}, {31'd0, want.solved});
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("weighted_two_term_least_squares_core test failed");
            $finish;
        end
    end

    initial
    begin
        wtls_pkg::sample_t directed[$];
        wtls_pkg::sample_t s;
        int n;
        int len;
        idle_mode    = IDLE_NONE;
        hold_off     = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        rst_n        = 1'b0;
        acc_11 = '0; acc_12 = '0; acc_22 = '0; acc_d1 = '0; acc_d2 = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty fit after reset, invalid last, singular pairs, extremes
        directed.push_back('{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b1});
        directed.push_back('{16'sd4096, 16'sd4096, 16'sd0, 16'd256, 1'b1, 1'b1});
        directed.push_back('{16'sd4096, 16'sd4096, 16'sd4096, 16'd256, 1'b1, 1'b0});
        directed.push_back('{16'sd4096, 16'sd4096, 16'sd4096, 16'd256, 1'b1, 1'b1});
        directed.push_back('{16'sd4096, 16'sd4096, 16'sd0, 16'd256, 1'b1, 1'b0});
        directed.push_back('{16'sd8192, 16'sd0, 16'sd4096, 16'd256, 1'b1, 1'b0});
        directed.push_back('{16'sd1234, 16'sd77, 16'sd99, 16'd999, 1'b0, 1'b1});
        directed.push_back('{16'sh7FFF, 16'sh0001, 16'sh0000, 16'hFFFF, 1'b1, 1'b0});
        directed.push_back('{16'sh8000, 16'sh0000, 16'sh0001, 16'hFFFF, 1'b1, 1'b1});
        directed.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b0});
        directed.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1, 1'b0});
        directed.push_back('{16'sh7FFF, 16'sh0001, 16'sh8000, 16'h0001, 1'b1, 1'b1});
        directed.push_back('{16'sh7FFF, 16'sh0001, 16'sh0000, 16'h0001, 1'b1, 1'b0});
        directed.push_back('{16'sh7FFF, 16'sh0000, 16'sh0001, 16'h0001, 1'b1, 1'b1});
        directed.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 1'b1, 1'b1});
        foreach (directed[i])
            send_beat(directed[i]);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (LONG_HOLD) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 12; k++)
                send_beat(rand_sample(1'b1, 1'b1));
        join
        wait_drained();

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            idle_mode = idle_mode_t'((n / 250) % 4);
            len = ($urandom_range(3) == 0) ? $urandom_range(30, 1) : $urandom_range(4, 1);
            for (int k = 0; k < len; k++)
            begin
                s = rand_sample(k == len - 1, $urandom_range(7) != 0);
                if ($urandom_range(19) == 0)
                    s = rand_sample(1'($urandom_range(1)), 1'b0);
                send_beat(s);
                n++;
            end
            if ($urandom_range(39) == 0)
                wait_drained();
        end
        send_beat(rand_sample(1'b1, 1'b1));
        idle_mode = IDLE_NONE;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && coef_queue.size() == 0)
            $display("weighted_two_term_least_squares_core test passed");
        else
            $display("weighted_two_term_least_squares_core test failed");
        $finish;
    end
endmodule
